FILE: src/mwm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mwm_pkg: shared types and constants of the mecanum wheel mixer
// Holds the job word that travels from the front end to the divider back end,
// the divider stage word and the configuration register indexes.
// ============================================================================
package mwm_pkg;

    localparam int WHEELS     = 4;
    localparam int QUOT_BITS  = 8;   // quotient never exceeds max_speed
    localparam int WHEEL_W    = 10;  // mixed wheel, -383..384
    localparam int MAG_W      = 9;   // wheel magnitude, 0..384
    localparam int NUM_W      = 17;  // magnitude times max_speed
    localparam int DRIVE_W    = 9;
    localparam int STICK_W    = 8;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 1;

    localparam logic [STICK_W-1:0]   CENTRE        = 8'd128;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 1'b1;

    // One classified sample: mixed wheels plus what the divider needs.
    typedef struct packed {
        logic                              scale;
        logic [MAG_W-1:0]                  largest;
        logic [WHEELS-1:0][WHEEL_W-1:0]    wheel;
        logic [WHEELS-1:0][NUM_W-1:0]      num;
    } mwm_job_t;

    // One divider stage: partial remainders and quotients of all four lanes.
    typedef struct packed {
        logic                              scale;
        logic [MAG_W-1:0]                  largest;
        logic [WHEELS-1:0][WHEEL_W-1:0]    wheel;
        logic [WHEELS-1:0][NUM_W-1:0]      rem;
        logic [WHEELS-1:0][QUOT_BITS-1:0]  quo;
    } mwm_div_t;

endpackage

FILE: src/mwm_front.sv
`timescale 1ns / 1ps
// ============================================================================
// mwm_front: sample intake and classification
// Centers the sticks, applies the dead zone, mixes four wheels, finds the
// largest magnitude and forms the scaling products. Two register stages.
// ============================================================================
module mwm_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [mwm_pkg::STICK_W-1:0]       stick_left_x,
    input  logic [mwm_pkg::STICK_W-1:0]       stick_left_y,
    input  logic [mwm_pkg::STICK_W-1:0]       stick_right_x,
    input  logic [mwm_pkg::CFG_W-1:0]         dead_zone,
    input  logic [mwm_pkg::CFG_W-1:0]         max_speed,
    input  logic                              q_full,
    output logic                              q_push,
    output mwm_pkg::mwm_job_t                 q_job
);
    import mwm_pkg::*;

    logic                              en;
    logic                              s1_valid_reg;
    logic                              s2_valid_reg;
    logic [WHEELS-1:0][WHEEL_W-1:0]    wheel_next;
    logic [WHEELS-1:0][WHEEL_W-1:0]    wheel_reg;
    mwm_job_t                          job_next;
    mwm_job_t                          job_reg;

    logic signed [WHEEL_W-1:0] ax_x, ax_y, ax_r;
    logic signed [WHEEL_W-1:0] dz_x, dz_y, dz_r;
    logic [WHEEL_W-1:0]        mg_x, mg_y, mg_r;
    logic [WHEEL_W-1:0]        dz_ext;
    logic [WHEELS-1:0][MAG_W-1:0] mag;
    logic [MAG_W-1:0]          big01, big23;

    // Hold the whole front end while the queue is full.
    assign en       = !q_full;
    assign in_ready = en;

    always_comb
    begin
        ax_x   = $signed({2'b00, stick_left_x}) - $signed({2'b00, CENTRE});
        ax_y   = $signed({2'b00, stick_left_y}) - $signed({2'b00, CENTRE});
        ax_r   = $signed({2'b00, CENTRE}) - $signed({2'b00, stick_right_x});
        mg_x   = ax_x[WHEEL_W-1] ? WHEEL_W'(-ax_x) : WHEEL_W'(ax_x);
        mg_y   = ax_y[WHEEL_W-1] ? WHEEL_W'(-ax_y) : WHEEL_W'(ax_y);
        mg_r   = ax_r[WHEEL_W-1] ? WHEEL_W'(-ax_r) : WHEEL_W'(ax_r);
        dz_ext = {2'b00, dead_zone};
        dz_x   = (mg_x < dz_ext) ? '0 : ax_x;
        dz_y   = (mg_y < dz_ext) ? '0 : ax_y;
        dz_r   = (mg_r < dz_ext) ? '0 : ax_r;
        wheel_next[0] = WHEEL_W'(-dz_y + dz_x + dz_r);
        wheel_next[1] = WHEEL_W'(-dz_y - dz_x - dz_r);
        wheel_next[2] = WHEEL_W'(-dz_y - dz_x + dz_r);
        wheel_next[3] = WHEEL_W'(-dz_y + dz_x - dz_r);
    end

    always_comb
    begin
        for (int i = 0; i < WHEELS; i++)
        begin
            mag[i] = wheel_reg[i][WHEEL_W-1] ? MAG_W'(-$signed(wheel_reg[i]))
                                             : MAG_W'(wheel_reg[i]);
        end
        big01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
        big23 = (mag[2] > mag[3]) ? mag[2] : mag[3];
        job_next.largest = (big01 > big23) ? big01 : big23;
        job_next.scale   = job_next.largest > {1'b0, max_speed};
        job_next.wheel   = wheel_reg;
        for (int i = 0; i < WHEELS; i++)
        begin
            job_next.num[i] = NUM_W'(mag[i]) * NUM_W'(max_speed);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wheel_reg <= wheel_next;
            job_reg   <= job_next;
        end
    end

    assign q_push = s2_valid_reg && en;
    assign q_job  = job_reg;

endmodule

FILE: src/mwm_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// mwm_queue: short job queue between front end and back end
// Small circular buffer; full and empty come straight from registers.
// ============================================================================
module mwm_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mwm_pkg::mwm_job_t    push_job,
    input  logic                 pop,
    output mwm_pkg::mwm_job_t    head_job,
    output logic                 full,
    output logic                 empty
);
    import mwm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mwm_job_t            mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: src/mwm_back.sv
`timescale 1ns / 1ps
// ============================================================================
// mwm_back: proportional scaling and output stage
// Pipelined restoring divider, one quotient bit per stage for all four
// wheels, followed by sign restore, right-side negation and output register.
// ============================================================================
module mwm_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  mwm_pkg::mwm_job_t             q_head,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mwm_pkg::DRIVE_W-1:0]   front_left_drive,
    output logic [mwm_pkg::DRIVE_W-1:0]   front_right_drive,
    output logic [mwm_pkg::DRIVE_W-1:0]   rear_left_drive,
    output logic [mwm_pkg::DRIVE_W-1:0]   rear_right_drive
);
    import mwm_pkg::*;

    localparam int SH_W = $clog2(QUOT_BITS);

    logic                              en;
    logic [QUOT_BITS:1]                vld_reg;
    mwm_div_t                          st_head;
    mwm_div_t                          st_reg  [1:QUOT_BITS];
    mwm_div_t                          st_next [1:QUOT_BITS];
    logic                              out_valid_reg;
    logic [WHEELS-1:0][DRIVE_W-1:0]    drive_reg;
    logic [WHEELS-1:0][DRIVE_W-1:0]    drive_next;
    logic [WHEELS-1:0][WHEEL_W-1:0]    final_w;
    mwm_div_t                          last;

    // One restoring step: try the divisor shifted to quotient bit sh.
    function automatic mwm_div_t div_step(input mwm_div_t s, input logic [SH_W-1:0] sh);
        mwm_div_t         r;
        logic [NUM_W-1:0] dsh;
        r   = s;
        dsh = NUM_W'(s.largest) << sh;
        for (int i = 0; i < WHEELS; i++)
        begin
            if (s.rem[i] >= dsh)
            begin
                r.rem[i]     = s.rem[i] - dsh;
                r.quo[i][sh] = 1'b1;
            end
        end
        return r;
    endfunction

    // Advance the whole back end whenever the output slot is free or drained.
    assign en    = !out_valid_reg || out_ready;
    assign q_pop = en && !q_empty;

    always_comb
    begin
        st_head.scale   = q_head.scale;
        st_head.largest = q_head.largest;
        st_head.wheel   = q_head.wheel;
        st_head.rem     = q_head.num;
        st_head.quo     = '0;
    end

    always_comb
    begin
        st_next[1] = div_step(st_head, SH_W'(QUOT_BITS - 1));
        for (int k = 2; k <= QUOT_BITS; k++)
        begin
            st_next[k] = div_step(st_reg[k-1], SH_W'(QUOT_BITS - k));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 1; k <= QUOT_BITS; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign last = st_reg[QUOT_BITS];

    always_comb
    begin
        for (int i = 0; i < WHEELS; i++)
        begin
            if (last.scale)
            begin
                final_w[i] = last.wheel[i][WHEEL_W-1]
                           ? WHEEL_W'(-$signed({2'b00, last.quo[i]}))
                           : {2'b00, last.quo[i]};
            end
            else
            begin
                final_w[i] = last.wheel[i];
            end
        end
        // Right-side motors are mounted mirrored: negate them.
        drive_next[0] = final_w[0][DRIVE_W-1:0];
        drive_next[1] = DRIVE_W'(-$signed(final_w[1]));
        drive_next[2] = final_w[2][DRIVE_W-1:0];
        drive_next[3] = DRIVE_W'(-$signed(final_w[3]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[QUOT_BITS-1:1], !q_empty};
            out_valid_reg <= vld_reg[QUOT_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            drive_reg <= drive_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign front_left_drive  = drive_reg[0];
    assign front_right_drive = drive_reg[1];
    assign rear_left_drive   = drive_reg[2];
    assign rear_right_drive  = drive_reg[3];

endmodule

FILE: src/mecanum_wheel_mixer.sv
`timescale 1ns / 1ps
// ============================================================================
// mecanum_wheel_mixer: joystick sample to four mecanum wheel drives
// Input channel (in_valid/in_ready) carries one transaction per joystick
// sample: three raw stick bytes centered at 128, the turn axis inverted.
// Output channel (out_valid/out_ready) carries one transaction per sample:
// four signed 9-bit drives, positive forward, negative backward, zero brake.
// Throughput is one sample per cycle while the output is not stalled. The
// accepting edge loads the first of two front-end stages (center, dead
// zone, mix; then largest magnitude and scaling products); the sample then
// passes one queue slot, eight restoring-divider stages (one quotient bit
// each) and the output register, which raises out_valid.
// The front end and the divider back end are split by a short queue, so a
// stall at the output holds the back end first; the front end keeps taking
// transactions until the queue fills, then drops in_ready.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 dead_zone, 1 max_speed) at the clock edge; write only while idle.
// Reset (rst_n low, asynchronous) empties the pipeline and queue and loads
// dead_zone = 20, max_speed = 255.
// ============================================================================
module mecanum_wheel_mixer
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [mwm_pkg::STICK_W-1:0]        stick_left_x,
    input  logic [mwm_pkg::STICK_W-1:0]        stick_left_y,
    input  logic [mwm_pkg::STICK_W-1:0]        stick_right_x,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [mwm_pkg::DRIVE_W-1:0]        front_left_drive,
    output logic [mwm_pkg::DRIVE_W-1:0]        front_right_drive,
    output logic [mwm_pkg::DRIVE_W-1:0]        rear_left_drive,
    output logic [mwm_pkg::DRIVE_W-1:0]        rear_right_drive,
    input  logic                               cfg_we,
    input  logic [mwm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mwm_pkg::CFG_W-1:0]          cfg_data
);
    import mwm_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0] dead_zone_reg;
    logic [CFG_W-1:0] max_speed_reg;

    // Queue handshake between front and back.
    logic     q_push, q_pop, q_full, q_empty;
    mwm_job_t q_job, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= 8'd20;
            max_speed_reg <= 8'd255;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEAD_ZONE: dead_zone_reg <= cfg_data;
                CFG_MAX_SPEED: max_speed_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Front end: center, dead zone, mix, classify for scaling.
    mwm_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .stick_left_x  (stick_left_x),
        .stick_left_y  (stick_left_y),
        .stick_right_x (stick_right_x),
        .dead_zone     (dead_zone_reg),
        .max_speed     (max_speed_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (q_job)
    );

    // Decouple front and back so each can stall on its own.
    mwm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head_job (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Back end: divide by the largest magnitude, restore signs, drive out.
    mwm_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_empty           (q_empty),
        .q_head            (q_head),
        .q_pop             (q_pop),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .front_left_drive  (front_left_drive),
        .front_right_drive (front_right_drive),
        .rear_left_drive   (rear_left_drive),
        .rear_right_drive  (rear_right_drive)
    );

endmodule

FILE: tb/mecanum_wheel_mixer_check.sv
`timescale 1ns / 1ps
// ============================================================================
// mecanum_wheel_mixer_check: drive predictor and scoreboard
// Watches the input, output and register write ports of the mixer, predicts
// the four wheel drives of every accepted sample and compares them, field by
// field and in order, with the drives that leave the block.
// ============================================================================
module mecanum_wheel_mixer_check
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [mwm_pkg::STICK_W-1:0]    stick_left_x,
    input  logic [mwm_pkg::STICK_W-1:0]    stick_left_y,
    input  logic [mwm_pkg::STICK_W-1:0]    stick_right_x,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [mwm_pkg::DRIVE_W-1:0]    front_left_drive,
    input  logic [mwm_pkg::DRIVE_W-1:0]    front_right_drive,
    input  logic [mwm_pkg::DRIVE_W-1:0]    rear_left_drive,
    input  logic [mwm_pkg::DRIVE_W-1:0]    rear_right_drive,
    input  logic                           cfg_we,
    input  logic [mwm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mwm_pkg::CFG_W-1:0]      cfg_data,
    output int                             mismatches,
    output int                             outstanding
);
    import mwm_pkg::*;

    typedef struct packed {
        logic [DRIVE_W-1:0] front_left;
        logic [DRIVE_W-1:0] front_right;
        logic [DRIVE_W-1:0] rear_left;
        logic [DRIVE_W-1:0] rear_right;
    } drive_set_t;

    drive_set_t       drives_due[$];
    logic [CFG_W-1:0] dead_zone_q;
    logic [CFG_W-1:0] max_speed_q;
    int               fail_count;

    // Center, dead-zone, mix, scale down past max speed, negate right side.
    function automatic drive_set_t mix_wheels(input logic [STICK_W-1:0] lx,
                                              input logic [STICK_W-1:0] ly,
                                              input logic [STICK_W-1:0] rx,
                                              input logic [CFG_W-1:0]   dz,
                                              input logic [CFG_W-1:0]   ms);
        int         axis [3];
        int         wheel [WHEELS];
        int         peak;
        int         m;
        int         flipped;
        drive_set_t d;
        axis[0] = int'(lx) - int'(CENTRE);
        axis[1] = int'(ly) - int'(CENTRE);
        axis[2] = int'(CENTRE) - int'(rx);
        for (int i = 0; i < 3; i++)
        begin
            if ((axis[i] < 0 ? -axis[i] : axis[i]) < int'(dz))
                axis[i] = 0;
        end
        wheel[0] = -axis[1] + axis[0] + axis[2];
        wheel[1] = -axis[1] - axis[0] - axis[2];
        wheel[2] = -axis[1] - axis[0] + axis[2];
        wheel[3] = -axis[1] + axis[0] - axis[2];
        peak = 0;
        for (int i = 0; i < WHEELS; i++)
        begin
            m = wheel[i] < 0 ? -wheel[i] : wheel[i];
            if (m > peak)
                peak = m;
        end
        if (peak > int'(ms))
        begin
            for (int i = 0; i < WHEELS; i++)
            begin
                m = (wheel[i] < 0 ? -wheel[i] : wheel[i]) * int'(ms) / peak;
                wheel[i] = wheel[i] < 0 ? -m : m;
            end
        end
        d.front_left = wheel[0][DRIVE_W-1:0];
        flipped      = -wheel[1];
        d.front_right = flipped[DRIVE_W-1:0];
        d.rear_left  = wheel[2][DRIVE_W-1:0];
        flipped      = -wheel[3];
        d.rear_right = flipped[DRIVE_W-1:0];
        return d;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        drive_set_t seen;
        drive_set_t want;
        if (!rst_n)
        begin
            drives_due.delete();
            dead_zone_q <= 8'd20;
            max_speed_q <= 8'd255;
            fail_count = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // Retire the result first so a same-edge accept cannot match it.
            if (out_valid && out_ready)
            begin
                seen = '{front_left_drive, front_right_drive,
                         rear_left_drive, rear_right_drive};
                if (drives_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"[%0t] unexpected drive transaction",
                                  " fl=%0d fr=%0d rl=%0d rr=%0d"},
                                 $realtime, $signed(seen.front_left),
                                 $signed(seen.front_right), $signed(seen.rear_left),
                                 $signed(seen.rear_right));
                end
                else
                begin
                    want = drives_due.pop_front();
                    if (seen.front_left  !== want.front_left  ||
                        seen.front_right !== want.front_right ||
                        seen.rear_left   !== want.rear_left   ||
                        seen.rear_right  !== want.rear_right)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"[%0t] drive mismatch",
                                      " exp fl=%0d fr=%0d rl=%0d rr=%0d",
                                      " got fl=%0d fr=%0d rl=%0d rr=%0d"},
                                     $realtime,
                                     $signed(want.front_left), $signed(want.front_right),
                                     $signed(want.rear_left), $signed(want.rear_right),
                                     $signed(seen.front_left), $signed(seen.front_right),
                                     $signed(seen.rear_left), $signed(seen.rear_right));
                    end
                end
            end
            if (in_valid && in_ready)
                drives_due.push_back(mix_wheels(stick_left_x, stick_left_y, stick_right_x,
                                                dead_zone_q, max_speed_q));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DEAD_ZONE: dead_zone_q <= cfg_data;
                    CFG_MAX_SPEED: max_speed_q <= cfg_data;
                    default: ;
                endcase
            end
            mismatches  <= fail_count;
            outstanding <= drives_due.size();
        end
    end

endmodule

FILE: tb/mecanum_wheel_mixer_test.sv
`timescale 1ns / 1ps
// ============================================================================
// mecanum_wheel_mixer_test: top of the mecanum wheel mixer testbench
// Drives joystick samples and register writes into the mixer, stalls the
// drive output at random and lets the checker predict and compare every
// drive transaction. Covers dead-zone edges, stick extremes and a range of
// dead-zone and max-speed settings under several idle and stall patterns.
// ============================================================================
module mecanum_wheel_mixer_test;
    import mwm_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 16;     // extra wait once nothing is outstanding
    localparam int RANDOM_ITEMS = 82;     // per register setting
    localparam int SETTINGS_N   = 10;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [STICK_W-1:0]   stick_left_x;
    logic [STICK_W-1:0]   stick_left_y;
    logic [STICK_W-1:0]   stick_right_x;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [DRIVE_W-1:0]   front_left_drive;
    logic [DRIVE_W-1:0]   front_right_drive;
    logic [DRIVE_W-1:0]   rear_left_drive;
    logic [DRIVE_W-1:0]   rear_right_drive;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int                   mismatches;
    int                   outstanding;
    int                   send_idle_pct;
    int                   ready_stall_pct;
    int                   cycle_count;

    mecanum_wheel_mixer dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .stick_left_x      (stick_left_x),
        .stick_left_y      (stick_left_y),
        .stick_right_x     (stick_right_x),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .front_left_drive  (front_left_drive),
        .front_right_drive (front_right_drive),
        .rear_left_drive   (rear_left_drive),
        .rear_right_drive  (rear_right_drive),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    mecanum_wheel_mixer_check checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .stick_left_x      (stick_left_x),
        .stick_left_y      (stick_left_y),
        .stick_right_x     (stick_right_x),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .front_left_drive  (front_left_drive),
        .front_right_drive (front_right_drive),
        .rear_left_drive   (rear_left_drive),
        .rear_right_drive  (rear_right_drive),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mismatches        (mismatches),
        .outstanding       (outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Stall the drive output at random; the percentage follows the phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= ready_stall_pct);
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Offer one sample after a random idle gap, hold it until accepted.
    // Valid only drops while idling, never in the step that raises it.
    task automatic send_sample(input logic [STICK_W-1:0] lx,
                               input logic [STICK_W-1:0] ly,
                               input logic [STICK_W-1:0] rx);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        stick_left_x  <= lx;
        stick_left_y  <= ly;
        stick_right_x <= rx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every predicted drive set has come back.
    // The checker's count is registered, so wait for the next edge before looking.
    task automatic drain_drives();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0]     value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Pick one stick byte: uniform, hugging the dead-zone edge, or extreme.
    function automatic logic [STICK_W-1:0] pick_stick(input logic [CFG_W-1:0] dz);
        int m;
        int choice;
        logic [STICK_W-1:0] corner [7];
        corner = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
        choice = $urandom_range(0, 3);
        if (choice == 2)
        begin
            m = int'(dz) + int'($urandom_range(0, 4)) - 2;
            if (m < 0)
                m = 0;
            if (m > 127)
                m = 127;
            return $urandom_range(0, 1) ? STICK_W'(128 + m) : STICK_W'(128 - m);
        end
        else if (choice == 3)
            return corner[$urandom_range(0, 6)];
        return STICK_W'($urandom_range(0, 255));
    endfunction

    initial
    begin : stimulus
        logic [CFG_W-1:0] dz_plan [SETTINGS_N];
        logic [CFG_W-1:0] ms_plan [SETTINGS_N];
        int               mode;

        // Register plan: defaults, both extremes of each, dead zone past 128
        // (everything brakes), max speed zero (everything scales to zero).
        dz_plan = '{8'd20, 8'd0, 8'd0,  8'd128, 8'd255, 8'd5,   8'd0, 8'd10,  8'd0, 8'd0};
        ms_plan = '{8'd255, 8'd255, 8'd0, 8'd1, 8'd200, 8'd100, 8'd1, 8'd254, 8'd0, 8'd0};
        dz_plan[8] = CFG_W'($urandom_range(0, 40));
        ms_plan[8] = CFG_W'($urandom_range(0, 255));
        dz_plan[9] = CFG_W'($urandom_range(0, 255));
        ms_plan[9] = CFG_W'($urandom_range(0, 255));

        send_idle_pct   = 0;
        ready_stall_pct = 0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        stick_left_x  <= CENTRE;
        stick_left_y  <= CENTRE;
        stick_right_x <= CENTRE;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_DEAD_ZONE;
        cfg_data      <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples on the reset registers (dead zone 20, max 255).
        send_sample(8'd128, 8'd128, 8'd128);   // centered: brake
        send_sample(8'd0,   8'd0,   8'd0);
        send_sample(8'd255, 8'd255, 8'd255);
        send_sample(8'd0,   8'd255, 8'd128);
        send_sample(8'd255, 8'd0,   8'd0);
        send_sample(8'd128, 8'd0,   8'd128);   // pure forward
        send_sample(8'd128, 8'd255, 8'd128);   // pure reverse
        send_sample(8'd0,   8'd128, 8'd128);   // pure strafe
        send_sample(8'd128, 8'd128, 8'd0);     // pure turn
        send_sample(8'd108, 8'd128, 8'd128);   // strafe left at dead-zone edge
        send_sample(8'd109, 8'd128, 8'd128);   // strafe just inside dead zone
        send_sample(8'd148, 8'd147, 8'd128);
        send_sample(8'd128, 8'd108, 8'd109);
        send_sample(8'd128, 8'd148, 8'd148);   // turn edge, inverted axis
        send_sample(8'd147, 8'd109, 8'd147);   // all axes inside dead zone
        send_sample(8'd0,   8'd0,   8'd255);   // near-largest mix, scaled down
        send_sample(8'd255, 8'd0,   8'd0);
        send_sample(8'd1,   8'd254, 8'd127);
        send_sample(8'd127, 8'd129, 8'd1);
        send_sample(8'd170, 8'd85,  8'd200);
        send_sample(8'd85,  8'd170, 8'd60);
        drain_drives();

        // Random phases: reprogram while idle, then cycle the idle patterns.
        for (int s = 0; s < SETTINGS_N; s++)
        begin
            write_reg(CFG_DEAD_ZONE, dz_plan[s]);
            write_reg(CFG_MAX_SPEED, ms_plan[s]);
            mode = s % 4;
            case (mode)
                0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
                1: begin send_idle_pct = 81; ready_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  ready_stall_pct = 81; end
                default: begin send_idle_pct = 22; ready_stall_pct = 22; end
            endcase
            for (int k = 0; k < RANDOM_ITEMS; k++)
            begin
                // Hold off once mid-phase until the pipeline has emptied.
                if (s == 3 && k == RANDOM_ITEMS / 2)
                    drain_drives();
                send_sample(pick_stick(dz_plan[s]), pick_stick(dz_plan[s]),
                            pick_stick(dz_plan[s]));
            end
            drain_drives();
        end

        // Let any stray transaction surface, then give the verdict.
        repeat (SETTLE_TICKS) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
